// ===== rtl/zobrist_position_hash_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef ZOBRIST_POSITION_HASH_CORE_DEFINES_SVH
`define ZOBRIST_POSITION_HASH_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ZPH_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("zobrist check failed");
// Next-cycle implication checked outside reset.
`define ZPH_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("zobrist check failed");
`endif

// ===== rtl/zph_pkg.sv =====
// Package with shared constants, types and functions of the Zobrist hash core.
package zph_pkg;
  localparam int unsigned KeyCount = 781;
  localparam int unsigned KeyAw = 10;
  localparam logic [9:0] SideKey = 10'd768;
  localparam logic [9:0] CastleKey = 10'd769;
  localparam logic [9:0] FileKey = 10'd773;
  localparam logic [63:0] SeedValue = 64'd20250307;
  localparam logic [63:0] LcgMul = 64'd6364136223846793005;
  localparam logic [63:0] LcgAdd = 64'd1442695040888963407;
  localparam logic [63:0] MixMulA = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB = 64'h94d049bb133111eb;

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpPiece = 2'd1;
  localparam logic [1:0] OpSide = 2'd2;
  localparam logic [1:0] OpMove = 2'd3;

  // Up to twelve key lookups per item.
  localparam int unsigned NumSlots = 12;

  typedef struct packed {
    logic       valid;
    logic [9:0] addr;
  } key_req_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       gen_start;   // begin generator step for next key
    logic       gen_write;   // write finished key
    logic       hash_load;   // capture item, start new accumulation
    logic       acc_xor;     // xor read data into accumulator
    logic [9:0] rd_addr;
    logic       rd_en;
    logic       commit;      // accumulator becomes running hash
    logic       clear;
  } zph_cmd_t;

  // Key address for signed piece p on square sq; invalid if no piece.
  function automatic key_req_t psq(input logic signed [4:0] p,
                                   input logic signed [7:0] sq);
    key_req_t r;
    logic [2:0] mag;
    logic [3:0] slot;
    logic [15:0] prod;
    mag = p[4] ? 3'((-p)) : p[2:0];
    r.valid = (p > -5'sd7) && (p < 5'sd7) && (p != 5'sd0)
              && (sq >= 8'sd0) && (sq <= 8'sd63);
    slot = {1'b0, mag - 3'd1} + (p[4] ? 4'd6 : 4'd0);
    prod = {slot, 6'd0, 6'd0} >> 6;
    r.addr = 10'({slot, sq[5:0]});
    if (prod == 16'hffff) r.valid = 1'b0;
    return r;
  endfunction
endpackage

// ===== rtl/zph_datapath.sv =====
// Datapath: key generator, key store, running hash and accumulator.
module zph_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  zph_pkg::zph_cmd_t  cmd,
  output logic               gen_done,
  output logic [63:0]        hash_value
);
  logic [63:0] key_mem [zph_pkg::KeyCount];
  logic [63:0] rd_data_r;
  logic        rd_vld_r;
  logic [9:0]  wr_addr_r, wr_addr_nxt;
  logic [63:0] gen_r;
  logic [63:0] mix_r;
  logic [4:0]  gstep_r;
  logic [63:0] lo_r;
  logic [31:0] crs_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] acc_r;
  logic [63:0] hash_r;

  assign gen_done = (gstep_r == 5'd16);
  assign wr_addr_nxt = wr_addr_r + 10'd1;

  // One 32x32 multiplier serves all three 64-bit products. Each product takes
  // the low-by-low term and then the two cross terms, of which only the low
  // half reaches the truncated result.
  always_comb begin
    case (gstep_r)
      5'd1: begin mul_a = gen_r[31:0]; mul_b = zph_pkg::LcgMul[31:0]; end
      5'd2: begin mul_a = gen_r[31:0]; mul_b = zph_pkg::LcgMul[63:32]; end
      5'd3: begin mul_a = gen_r[63:32]; mul_b = zph_pkg::LcgMul[31:0]; end
      5'd6: begin mul_a = mix_r[31:0]; mul_b = zph_pkg::MixMulA[31:0]; end
      5'd7: begin mul_a = mix_r[31:0]; mul_b = zph_pkg::MixMulA[63:32]; end
      5'd8: begin mul_a = mix_r[63:32]; mul_b = zph_pkg::MixMulA[31:0]; end
      5'd11: begin mul_a = mix_r[31:0]; mul_b = zph_pkg::MixMulB[31:0]; end
      5'd12: begin mul_a = mix_r[31:0]; mul_b = zph_pkg::MixMulB[63:32]; end
      5'd13: begin mul_a = mix_r[63:32]; mul_b = zph_pkg::MixMulB[31:0]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // Generator: LCG step then mixer, one partial product per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= zph_pkg::SeedValue;
      gstep_r <= 5'd0;
      wr_addr_r <= '0;
    end else if (cmd.gen_start) begin
      gstep_r <= 5'd1;
    end else begin
      case (gstep_r)
        5'd1, 5'd6, 5'd11: begin
          lo_r <= mul_p;
          gstep_r <= gstep_r + 5'd1;
        end
        5'd2, 5'd7, 5'd12: begin
          crs_r <= mul_p[31:0];
          gstep_r <= gstep_r + 5'd1;
        end
        5'd3, 5'd8, 5'd13: begin
          crs_r <= crs_r + mul_p[31:0];
          gstep_r <= gstep_r + 5'd1;
        end
        5'd4: begin
          gen_r <= lo_r + {crs_r, 32'd0} + zph_pkg::LcgAdd;
          gstep_r <= 5'd5;
        end
        5'd5: begin mix_r <= gen_r ^ (gen_r >> 30); gstep_r <= 5'd6; end
        5'd9, 5'd14: begin
          mix_r <= lo_r + {crs_r, 32'd0};
          gstep_r <= gstep_r + 5'd1;
        end
        5'd10: begin mix_r <= mix_r ^ (mix_r >> 27); gstep_r <= 5'd11; end
        5'd15: begin mix_r <= mix_r ^ (mix_r >> 31); gstep_r <= 5'd16; end
        5'd16: begin
          if (cmd.gen_write) begin
            wr_addr_r <= wr_addr_nxt;
            gstep_r <= 5'd0;
          end
        end
        default: gstep_r <= gstep_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_write) key_mem[wr_addr_r] <= mix_r;
    if (cmd.rd_en) rd_data_r <= key_mem[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      hash_r <= '0;
      acc_r <= '0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.hash_load) acc_r <= hash_r;
      else if (cmd.acc_xor && rd_vld_r) acc_r <= acc_r ^ rd_data_r;
      if (cmd.clear) hash_r <= '0;
      else if (cmd.commit) hash_r <= acc_r;
    end
  end

  assign hash_value = hash_r;
endmodule

// ===== rtl/zph_controller.sv =====
// Controller: key fill sequencing and per-item lookup sequencing.
module zph_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  logic [1:0]         opcode,
  input  logic [5:0]         from_square,
  input  logic [5:0]         to_square,
  input  logic signed [3:0]  mover_code,
  input  logic signed [3:0]  victim_code,
  input  logic [2:0]         promotion_type,
  input  logic [3:0]         castling_before,
  input  logic [3:0]         castling_after,
  input  logic signed [6:0]  ep_square_before,
  input  logic signed [6:0]  ep_square_after,
  input  logic               side_black,
  input  logic               gen_done,
  input  logic               out_free,
  output logic               item_ready,
  output logic               result_push,
  output logic               bad_piece,
  output zph_pkg::zph_cmd_t  cmd
);
  typedef enum logic [2:0] {
    S_FILL, S_IDLE, S_READ, S_DRAIN, S_COMMIT, S_DONE
  } state_t;

  state_t state_r;
  logic [9:0] fill_cnt_r;
  logic       gen_busy_r;
  zph_pkg::key_req_t req_r [zph_pkg::NumSlots];
  zph_pkg::key_req_t req_nxt [zph_pkg::NumSlots];
  logic [3:0] slot_r;
  logic       bad_r, bad_nxt;
  logic       clear_r;

  // Build the list of lookups for an item.
  always_comb begin
    logic signed [4:0] mv, cp, col, landed, rook;
    logic signed [7:0] fr, tq;
    logic [2:0] mag;
    for (int i = 0; i < zph_pkg::NumSlots; i++) req_nxt[i] = '0;
    mv = 5'(mover_code);
    cp = 5'(victim_code);
    fr = 8'({2'b00, from_square});
    tq = 8'({2'b00, to_square});
    mag = mover_code[3] ? 3'(-mv) : 3'(mover_code);
    col = mover_code[3] ? -5'sd1 : 5'sd1;
    landed = (promotion_type >= 3'd1 && promotion_type <= 3'd6)
             ? (mover_code[3] ? -5'($signed({2'b00, promotion_type}))
                              : 5'($signed({2'b00, promotion_type}))) : mv;
    rook = mover_code[3] ? -5'sd4 : 5'sd4;
    bad_nxt = 1'b0;
    case (opcode)
      zph_pkg::OpPiece: req_nxt[0] = zph_pkg::psq(mv, fr);
      zph_pkg::OpSide: begin
        req_nxt[0] = '{side_black, zph_pkg::SideKey};
        for (int i = 0; i < 4; i++)
          req_nxt[1 + i] = '{castling_after[i], zph_pkg::CastleKey + 10'(i)};
        req_nxt[5] = '{!ep_square_after[6],
                       zph_pkg::FileKey + 10'(ep_square_after[2:0])};
      end
      zph_pkg::OpMove: begin
        if (mag < 3'd1 || mag > 3'd6 || mover_code == -4'sd8) begin
          bad_nxt = 1'b1;
        end else begin
          req_nxt[0] = zph_pkg::psq(mv, fr);
          req_nxt[1] = zph_pkg::psq(cp, tq);
          if (mag == 3'd1 && !ep_square_before[6]
              && to_square == ep_square_before[5:0])
            req_nxt[2] = zph_pkg::psq(-col, tq - (mover_code[3] ? -8'sd8 : 8'sd8));
          req_nxt[3] = zph_pkg::psq(landed, tq);
          if (mag == 3'd6 && tq - fr == 8'sd2) begin
            req_nxt[4] = zph_pkg::psq(rook, fr + 8'sd3);
            req_nxt[5] = zph_pkg::psq(rook, fr + 8'sd1);
          end else if (mag == 3'd6 && tq - fr == -8'sd2) begin
            req_nxt[4] = zph_pkg::psq(rook, fr - 8'sd4);
            req_nxt[5] = zph_pkg::psq(rook, fr - 8'sd1);
          end
          req_nxt[6] = '{1'b1, zph_pkg::SideKey};
          // Rights that change toggle; unchanged ones cancel.
          for (int i = 0; i < 4; i++)
            req_nxt[7 + i] = '{castling_before[i] ^ castling_after[i],
                               zph_pkg::CastleKey + 10'(i)};
          // En-passant keys: both go through the slot pair 4/5 when unused.
          if (!(mag == 3'd6 && (tq - fr == 8'sd2 || tq - fr == -8'sd2))) begin
            req_nxt[4] = '{!ep_square_before[6],
                           zph_pkg::FileKey + 10'(ep_square_before[2:0])};
            req_nxt[5] = '{!ep_square_after[6],
                           zph_pkg::FileKey + 10'(ep_square_after[2:0])};
          end else begin
            // Castling king move: the pawn slot is free for the old file,
            // and the new file takes the last slot.
            req_nxt[2] = '{!ep_square_before[6],
                           zph_pkg::FileKey + 10'(ep_square_before[2:0])};
            req_nxt[11] = '{!ep_square_after[6],
                            zph_pkg::FileKey + 10'(ep_square_after[2:0])};
          end
        end
      end
      default: ;
    endcase
  end

  assign item_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.gen_start = (state_r == S_FILL) && !gen_busy_r && (fill_cnt_r != 10'(zph_pkg::KeyCount));
    cmd.gen_write = (state_r == S_FILL) && gen_done;
    cmd.hash_load = item_ready && item_valid;
    cmd.rd_en = (state_r == S_READ) && req_r[slot_r].valid;
    cmd.rd_addr = req_r[slot_r].addr;
    cmd.acc_xor = (state_r == S_READ) || (state_r == S_DRAIN);
    cmd.commit = (state_r == S_COMMIT) && !bad_r;
    cmd.clear = (state_r == S_COMMIT) && clear_r;
  end

  assign result_push = (state_r == S_DONE) && out_free;
  assign bad_piece = bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      fill_cnt_r <= '0;
      gen_busy_r <= 1'b0;
      slot_r <= '0;
      bad_r <= 1'b0;
      clear_r <= 1'b0;
    end else begin
      case (state_r)
        S_FILL: begin
          if (cmd.gen_start) gen_busy_r <= 1'b1;
          if (cmd.gen_write) begin
            gen_busy_r <= 1'b0;
            fill_cnt_r <= fill_cnt_r + 10'd1;
          end
          if (fill_cnt_r == 10'(zph_pkg::KeyCount)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd.hash_load) begin
            for (int i = 0; i < zph_pkg::NumSlots; i++) req_r[i] <= req_nxt[i];
            bad_r <= bad_nxt;
            clear_r <= (opcode == zph_pkg::OpClear);
            slot_r <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (slot_r == 4'(zph_pkg::NumSlots - 1)) state_r <= S_DRAIN;
          else slot_r <= slot_r + 4'd1;
        end
        S_DRAIN: state_r <= S_COMMIT;
        S_COMMIT: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_FILL;
      endcase
    end
  end
endmodule

// ===== rtl/zobrist_position_hash_core.sv =====
// Top level of the Zobrist position hash core.
// After reset the core generates its 781-word key store, one key at a time by
// the generator that forms each of its three 64-bit products from 32-bit
// partial products on one shared multiplier, and accepts no transaction until
// that fill is done. Each accepted transaction then runs twelve key-store read
// slots through the single read port, a drain state and a commit state for the
// running hash, and a final state that loads the output register. The core
// takes the next transaction only once it is back in its idle state. The result
// register lets the next transaction be accepted while the previous result
// still waits; a second result then holds the core until the output register
// is free.
module zobrist_position_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Fields from bit 0: opcode[1:0], from_square[7:2], to_square[13:8],
  // mover piece[17:14], victim piece[21:18], promotion_type[24:22],
  // castling_before[28:25], castling_after[32:29], ep_square_before[39:33],
  // ep_square_after[46:40], black side to move[47].
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Fields from bit 0: hash_value[63:0], bad_piece[64], zero fill above.
  output logic [71:0] out_tdata
);
  zph_pkg::zph_cmd_t cmd;
  logic gen_done, result_push, bad_piece, item_ready;
  logic [63:0] hash_value;
  logic out_valid_r;
  logic [64:0] out_data_r;
  logic out_free;

  // The controller waits until the output slot is empty or being drained.
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = item_ready;

  zph_controller u_ctrl (
    .clk, .rst_n,
    .item_valid(in_tvalid),
    .opcode(in_tdata[1:0]),
    .from_square(in_tdata[7:2]),
    .to_square(in_tdata[13:8]),
    .mover_code(in_tdata[17:14]),
    .victim_code(in_tdata[21:18]),
    .promotion_type(in_tdata[24:22]),
    .castling_before(in_tdata[28:25]),
    .castling_after(in_tdata[32:29]),
    .ep_square_before(in_tdata[39:33]),
    .ep_square_after(in_tdata[46:40]),
    .side_black(in_tdata[47]),
    .gen_done, .out_free,
    .item_ready, .result_push, .bad_piece, .cmd
  );

  zph_datapath u_dp (
    .clk, .rst_n, .cmd, .gen_done, .hash_value
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (result_push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_push) out_data_r <= {bad_piece, hash_value};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {7'd0, out_data_r};
endmodule

// ===== rtl/zph_checker.sv =====
// Port-level checker for the Zobrist hash core and its bind.
`include "zobrist_position_hash_core_defines.svh"
module zph_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);
  `ZPH_ASSERT_NXT(a_one_item_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ZPH_ASSERT_NXT(a_out_holds, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `ZPH_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[71:65] == 7'd0)
endmodule

bind zobrist_position_hash_core zph_checker u_zph_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the Zobrist position hash core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected hash results, oldest first, and the model of the running hash.
  class hash_scoreboard;
    logic [63:0] keys [0:780];
    logic [63:0] hash_now;
    logic [64:0] pending [$];
    int errors;
    int checked;

    function void build_keys();
      logic [63:0] gen;
      logic [63:0] x;
      gen = zph_pkg::SeedValue;
      for (int i = 0; i < 781; i++) begin
        gen = gen * zph_pkg::LcgMul + zph_pkg::LcgAdd;
        x = gen;
        x = x ^ (x >> 30);
        x = x * zph_pkg::MixMulA;
        x = x ^ (x >> 27);
        x = x * zph_pkg::MixMulB;
        x = x ^ (x >> 31);
        keys[i] = x;
      end
      hash_now = '0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [63:0] sq_key(int p, int sq);
      int mag;
      int slot;
      mag = p < 0 ? -p : p;
      if (mag < 1 || mag > 6 || sq < 0 || sq > 63) return '0;
      slot = mag - 1 + (p > 0 ? 0 : 6);
      return keys[slot * 64 + sq];
    endfunction

    function logic [63:0] rights_key(logic [3:0] bits);
      logic [63:0] h;
      h = '0;
      for (int i = 0; i < 4; i++)
        if (bits[i]) h = h ^ keys[zph_pkg::CastleKey + i];
      return h;
    endfunction

    function logic [63:0] file_key(int ep);
      if (ep < 0) return '0;
      return keys[zph_pkg::FileKey + (ep & 7)];
    endfunction

    // Predicts the result for one accepted input transaction.
    function void note_input(logic [47:0] d);
      logic [1:0] op;
      int from_sq, to_sq, moved, capt, promo, epb, epa, mag, colour, landed;
      logic [3:0] cb, ca;
      logic [63:0] h;
      logic bad;
      op = d[1:0];
      from_sq = d[7:2];
      to_sq = d[13:8];
      moved = $signed(d[17:14]);
      capt = $signed(d[21:18]);
      promo = d[24:22];
      cb = d[28:25];
      ca = d[32:29];
      epb = $signed(d[39:33]);
      epa = $signed(d[46:40]);
      bad = 1'b0;
      case (op)
        zph_pkg::OpClear: hash_now = '0;
        zph_pkg::OpPiece: hash_now = hash_now ^ sq_key(moved, from_sq);
        zph_pkg::OpSide: begin
          if (d[47]) hash_now = hash_now ^ keys[zph_pkg::SideKey];
          hash_now = hash_now ^ rights_key(ca) ^ file_key(epa);
        end
        default: begin
          mag = moved < 0 ? -moved : moved;
          if (mag < 1 || mag > 6) begin
            bad = 1'b1;
          end else begin
            colour = moved > 0 ? 1 : -1;
            landed = (promo >= 1 && promo <= 6) ? colour * promo : moved;
            h = hash_now ^ sq_key(moved, from_sq) ^ sq_key(capt, to_sq);
            // A pawn landing on the en-passant square takes the pawn behind it.
            if (mag == 1 && epb >= 0 && to_sq == epb)
              h = h ^ sq_key(-colour, to_sq - 8 * colour);
            h = h ^ sq_key(landed, to_sq);
            if (mag == 6 && to_sq - from_sq == 2)
              h = h ^ sq_key(4 * colour, from_sq + 3) ^ sq_key(4 * colour, from_sq + 1);
            else if (mag == 6 && to_sq - from_sq == -2)
              h = h ^ sq_key(4 * colour, from_sq - 4) ^ sq_key(4 * colour, from_sq - 1);
            h = h ^ keys[zph_pkg::SideKey] ^ rights_key(cb) ^ rights_key(ca);
            hash_now = h ^ file_key(epb) ^ file_key(epa);
          end
        end
      endcase
      pending.push_back({bad, hash_now});
    endfunction

    function void check_result(logic [71:0] d);
      logic [64:0] want;
      if (pending.size() == 0) begin
        $error("result with no expectation: hash_value %h", d[63:0]);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (d[63:0] !== want[63:0]) begin
        $error("hash_value expected %h actual %h", want[63:0], d[63:0]);
        errors++;
      end
      if (d[64] !== want[64]) begin
        $error("bad_piece expected %0d actual %0d", want[64], d[64]);
        errors++;
      end
      if (d[71:65] !== 7'd0) begin
        $error("zero fill expected 0 actual %h", d[71:65]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;

  hash_scoreboard board;
  int cycle_count = 0;
  int sent = 0;
  // When set, the result side stops taking transactions for a long stretch.
  logic hold_results = 1'b0;
  int move_count = 0;

  zobrist_position_hash_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Generous limit: it covers the key fill, and every transaction may see random
  // gap cycles on each side plus its own work.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAIL zobrist_position_hash_core");
      $finish;
    end
  end

  // Both handshakes are sampled at the same edge the block sees them.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // Packs the fields of one input transaction, lowest field first.
  function automatic logic [47:0] pack_item(logic [1:0] op, logic [5:0] from_sq,
      logic [5:0] to_sq, logic [3:0] moved, logic [3:0] capt, logic [2:0] promo,
      logic [3:0] cb, logic [3:0] ca, logic [6:0] epb, logic [6:0] epa, logic btm);
    return {btm, epa, epb, ca, cb, promo, capt, moved, to_sq, from_sq, op};
  endfunction

  // Offers one transaction, after a random gap if with_gap is set, and holds it until taken.
  // Valid stays high after acceptance so back-to-back transactions need no
  // second assignment in the same step; gaps and pauses drop it first.
  task automatic send_item(logic [47:0] d, bit with_gap);
    int gap;
    gap = with_gap ? $urandom_range(16, 0) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // A random piece code: mostly real pieces, sometimes empty or invalid.
  function automatic logic [3:0] rand_piece();
    logic [3:0] mag;
    if ($urandom_range(9, 0) == 0) return 4'($urandom_range(15, 0));
    mag = 4'($urandom_range(6, 1));
    return $urandom_range(1, 0) ? mag : 4'(-mag);
  endfunction

  function automatic logic [6:0] rand_ep();
    int r;
    r = $urandom_range(9, 0);
    if (r < 4) return 7'h7f;
    if (r == 4) return 7'($urandom_range(127, 64));
    return 7'($urandom_range(63, 0));
  endfunction

  // A move update with random content, shaped toward the special cases.
  function automatic logic [47:0] rand_move();
    logic [5:0] from_sq, to_sq;
    logic [3:0] moved;
    logic [6:0] epb;
    int kind;
    kind = $urandom_range(5, 0);
    from_sq = 6'($urandom_range(63, 0));
    to_sq = 6'($urandom_range(63, 0));
    moved = rand_piece();
    epb = rand_ep();
    if (kind == 0) begin
      // King moves two files either way.
      moved = $urandom_range(1, 0) ? 4'd6 : 4'(-6);
      to_sq = $urandom_range(1, 0) ? from_sq + 6'd2 : from_sq - 6'd2;
    end else if (kind == 1) begin
      // Pawn arriving on the en-passant square.
      moved = $urandom_range(1, 0) ? 4'd1 : 4'(-1);
      epb = {1'b0, to_sq};
    end
    return pack_item(zph_pkg::OpMove, from_sq, to_sq, moved, rand_piece(),
                     3'($urandom_range(7, 0)), 4'($urandom_range(15, 0)),
                     4'($urandom_range(15, 0)), epb, rand_ep(), 1'($urandom_range(1, 0)));
  endfunction

  function automatic logic [47:0] rand_item();
    int r;
    r = $urandom_range(19, 0);
    if (r == 0) return pack_item(zph_pkg::OpClear, 6'($urandom), 6'($urandom),
                                 4'($urandom), 4'($urandom), 3'($urandom), 4'($urandom),
                                 4'($urandom), 7'($urandom), 7'($urandom), 1'($urandom));
    if (r < 6) return pack_item(zph_pkg::OpPiece, 6'($urandom_range(63, 0)), 6'($urandom),
                                rand_piece(), 4'($urandom), 3'($urandom), 4'($urandom),
                                4'($urandom), 7'($urandom), 7'($urandom), 1'($urandom));
    if (r < 9) return pack_item(zph_pkg::OpSide, 6'($urandom), 6'($urandom), 4'($urandom),
                                4'($urandom), 3'($urandom), 4'($urandom),
                                4'($urandom_range(15, 0)), 7'($urandom), rand_ep(),
                                1'($urandom_range(1, 0)));
    move_count++;
    return rand_move();
  endfunction

  // Stops offering, waits until the last accepted transaction is noted, then
  // waits until every expected result has come.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, with stretches of none and one long hold.
  initial begin
    int stall;
    @(posedge clk);
    wait (rst_n);
    forever begin
      if (hold_results) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end else begin
        stall = ((sent / 200) % 3 == 1) ? 0 : $urandom_range(16, 0);
        if (stall != 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
        while (!(out_tvalid && out_tready)) @(posedge clk);
      end
    end
  end

  // Holds results back for a long stretch so the block fills up and stalls.
  initial begin
    wait (sent >= 300);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (400) @(posedge clk);
    hold_results <= 1'b0;
  end

  initial begin
    int tail;
    board = new();
    board.build_keys();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: every opcode, field extremes and the special cases.
    send_item(pack_item(zph_pkg::OpClear, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1), 1'b1);
    send_item(pack_item(zph_pkg::OpPiece, 6'd0, 6'd0, 4'd1, 4'd0, 3'd0, 4'd0, 4'd0,
                        7'd0, 7'd0, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpPiece, 6'd63, 6'd0, 4'(-6), 4'd0, 3'd0, 4'd0, 4'd0,
                        7'd0, 7'd0, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpPiece, 6'd5, 6'd0, 4'd7, 4'd0, 3'd0, 4'd0, 4'd0,
                        7'd0, 7'd0, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpPiece, 6'd9, 6'd0, 4'(-8), 4'd0, 3'd0, 4'd0, 4'd0,
                        7'd0, 7'd0, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpSide, 6'd0, 6'd0, 4'd0, 4'd0, 3'd0, 4'd0, 4'hf,
                        7'd0, 7'd63, 1'b1), 1'b1);
    send_item(pack_item(zph_pkg::OpSide, 6'd0, 6'd0, 4'd0, 4'd0, 3'd0, 4'd0, 4'h0,
                        7'd0, 7'h7f, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpSide, 6'd0, 6'd0, 4'd0, 4'd0, 3'd0, 4'd0, 4'h5,
                        7'd0, 7'h40, 1'b1), 1'b1);
    // Empty and invalid moved piece leave the hash alone and flag it.
    send_item(pack_item(zph_pkg::OpMove, 6'd12, 6'd28, 4'd0, 4'd0, 3'd0, 4'hf, 4'h0,
                        7'd0, 7'd0, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd12, 6'd28, 4'(-7), 4'd0, 3'd0, 4'hf, 4'h0,
                        7'd0, 7'd0, 1'b0), 1'b1);
    // Plain move, capture, promotions including code seven.
    send_item(pack_item(zph_pkg::OpMove, 6'd12, 6'd28, 4'd1, 4'd0, 3'd0, 4'hf, 4'hf,
                        7'h7f, 7'd20, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd52, 6'd61, 4'(-1), 4'd3, 3'd5, 4'h0, 4'h0,
                        7'h7f, 7'h7f, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd52, 6'd60, 4'd1, 4'(-7), 3'd7, 4'h0, 4'h0,
                        7'h7f, 7'h7f, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd8, 6'd0, 4'(-1), 4'd6, 3'd6, 4'h0, 4'h0,
                        7'h7f, 7'h7f, 1'b0), 1'b1);
    // En-passant captures, two whose victim squares fall off the board.
    send_item(pack_item(zph_pkg::OpMove, 6'd36, 6'd43, 4'd1, 4'd0, 3'd0, 4'h0, 4'h0,
                        7'd43, 7'h7f, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd27, 6'd18, 4'(-1), 4'd0, 3'd0, 4'h0, 4'h0,
                        7'd18, 7'h7f, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd10, 6'd3, 4'd1, 4'd0, 3'd0, 4'h0, 4'h0,
                        7'd3, 7'h7f, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd53, 6'd60, 4'(-1), 4'd0, 3'd0, 4'h0, 4'h0,
                        7'd60, 7'h7f, 1'b0), 1'b1);
    // Castling both ways, both colors, and rook squares off the board.
    send_item(pack_item(zph_pkg::OpMove, 6'd4, 6'd6, 4'd6, 4'd0, 3'd0, 4'hf, 4'hc,
                        7'h7f, 7'h7f, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd60, 6'd58, 4'(-6), 4'd0, 3'd0, 4'hc, 4'h0,
                        7'h7f, 7'h7f, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd61, 6'd63, 4'd6, 4'd0, 3'd0, 4'h0, 4'h0,
                        7'h7f, 7'h7f, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd2, 6'd0, 4'(-6), 4'd0, 3'd0, 4'h0, 4'h0,
                        7'd21, 7'd42, 1'b0), 1'b1);
    send_item(pack_item(zph_pkg::OpMove, 6'd63, 6'd63, 4'(-2), 4'(-6), 3'd4, 4'hf, 4'hf,
                        7'd63, 7'h40, 1'b1), 1'b1);

    // Random part. After 800 transactions the sender pauses until all results are in.
    for (int i = 0; i < 1630; i++) begin
      if (i == 800) wait_drained();
      send_item(rand_item(), ((i / 150) % 4) != 2);
    end
    wait_drained();
    tail = 0;
    while (tail < 40) begin
      @(posedge clk);
      tail++;
    end
    $display("Sent %0d transactions (%0d random move updates), checked %0d results,",
             sent, move_count, board.checked);
    $display("with idle gaps on both sides and a long result-side hold.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS zobrist_position_hash_core");
    end else begin
      $display("FAIL zobrist_position_hash_core");
    end
    $finish;
  end
endmodule
